// ----- rtl/ips_pkg.sv -----
// Shared constants and types for the intercept point solver.
`timescale 1ns / 1ps
package ips_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// which quotient becomes the time
	typedef enum logic [1:0] {
		SEL_A,   // numerator over a
		SEL_B,   // c over the stable root f
		SEL_MIN  // smaller of the two
	} tsel_t;

	// per-word control that rides along the divider
	typedef struct packed {
		tsel_t sel;
		logic  deg;
		logic  neg_a;
		logic  neg_b;
	} ctl_t;

endpackage

// ----- rtl/intercept_point_solver_core.sv -----
// Intercept point solver: pipelined lead-point computation in signed fixed point.
`timescale 1ns / 1ps
//
// Channel   Handshake        Fields
// --------  ---------------  ----------------------------------------------
// request   start / busy     lead_speed, pos_x, pos_y, vel_x, vel_y
// result    done (strobe)    aim_x, aim_y, degenerate
//
// One word enters per clock; busy is never raised. The latency is set by the
// square-root pipeline (one root bit per stage) and the two parallel
// restoring dividers (one quotient bit per stage). The result strobe is high
// for exactly one cycle per word; the receiver cannot stall, so nothing ever
// backs up. Reset clears only the valid bits of the stages.
//
module intercept_point_solver_core
	import ips_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic        [WORD_WIDTH-2:0] lead_speed,
	input  logic signed [WORD_WIDTH-1:0] pos_x,
	input  logic signed [WORD_WIDTH-1:0] pos_y,
	input  logic signed [WORD_WIDTH-1:0] vel_x,
	input  logic signed [WORD_WIDTH-1:0] vel_y,
	output logic                         done,
	output logic signed [WORD_WIDTH-1:0] aim_x,
	output logic signed [WORD_WIDTH-1:0] aim_y,
	output logic                         degenerate
);

	// widths
	localparam int W    = WORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int MW   = 2*W;          // products, magnitudes of a, b, c
	localparam int AW   = 2*W + 1;      // signed a, b, c
	localparam int DW   = 4*W + 1;      // signed discriminant
	localparam int RW   = 4*W;          // radicand
	localparam int QW   = 2*W;          // root
	localparam int RMW  = 2*W + 2;      // root remainder
	localparam int FW   = 2*W + 2;      // signed stable root f
	localparam int DVW  = 2*W + 1;      // divisor / numerator magnitude
	localparam int NW   = DVW + F;      // shifted numerator, quotient
	localparam int ACW  = DVW + NW;     // remainder : numerator
	localparam int TCH  = NW / W + 1;   // W-bit chunks of the time
	localparam int TPW  = TCH * W;
	localparam int PPW  = 2*W + 1;      // chunk times velocity
	localparam int PW   = TPW + W + 1;  // t*v
	localparam int SW   = PW + 1;       // p + t*v
	localparam int LAT  = QW + NW + 12;

	localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

	logic take;
	assign busy = 1'b0;
	assign take = start & ~busy;

	// ---------------- s1: the seven dot-product terms ----------------
	logic                 vld_s1;
	logic signed [MW-1:0] xx_s1, yy_s1, ss_s1, pxv_s1, pyv_s1, pxx_s1, pyy_s1;
	logic        [4*W-1:0] pv_s1;
	logic signed [W-1:0]  spd_w;
	assign spd_w = $signed({1'b0, lead_speed});

	always_ff @(posedge clk) begin
		xx_s1  <= vel_x * vel_x;
		yy_s1  <= vel_y * vel_y;
		ss_s1  <= spd_w * spd_w;
		pxv_s1 <= pos_x * vel_x;
		pyv_s1 <= pos_y * vel_y;
		pxx_s1 <= pos_x * pos_x;
		pyy_s1 <= pos_y * pos_y;
		pv_s1  <= {pos_x, pos_y, vel_x, vel_y};
	end

	// ---------------- s2: a, half-b, c ----------------
	logic                 vld_s2;
	logic signed [AW-1:0] a_s2, b_s2, c_s2;
	logic        [4*W-1:0] pv_s2;

	always_ff @(posedge clk) begin
		a_s2  <= AW'(xx_s1) + AW'(yy_s1) - AW'(ss_s1);
		b_s2  <= AW'(pxv_s1) + AW'(pyv_s1);
		c_s2  <= AW'(pxx_s1) + AW'(pyy_s1);
		pv_s2 <= pv_s1;
	end

	// ---------------- s3: magnitudes for the wide squares ----------------
	logic                  vld_s3;
	logic        [MW-1:0]  am_s3, bm_s3, cm_s3;
	logic        [3*AW-1:0] abc_s3;
	logic        [4*W-1:0]  pv_s3;

	always_ff @(posedge clk) begin
		am_s3  <= a_s2[AW-1] ? MW'(-a_s2) : MW'(a_s2);
		bm_s3  <= b_s2[AW-1] ? MW'(-b_s2) : MW'(b_s2);
		cm_s3  <= MW'(c_s2);
		abc_s3 <= {a_s2, b_s2, c_s2};
		pv_s3  <= pv_s2;
	end

	// ---------------- s4: half-word partial products ----------------
	logic                  vld_s4;
	logic        [MW-1:0]  bhh_s4, bhl_s4, bll_s4, ahch_s4, ahcl_s4, alch_s4, alcl_s4;
	logic        [3*AW-1:0] abc_s4;
	logic        [4*W-1:0]  pv_s4;

	always_ff @(posedge clk) begin
		bhh_s4  <= bm_s3[MW-1:W] * bm_s3[MW-1:W];
		bhl_s4  <= bm_s3[MW-1:W] * bm_s3[W-1:0];
		bll_s4  <= bm_s3[W-1:0]  * bm_s3[W-1:0];
		ahch_s4 <= am_s3[MW-1:W] * cm_s3[MW-1:W];
		ahcl_s4 <= am_s3[MW-1:W] * cm_s3[W-1:0];
		alch_s4 <= am_s3[W-1:0]  * cm_s3[MW-1:W];
		alcl_s4 <= am_s3[W-1:0]  * cm_s3[W-1:0];
		abc_s4  <= abc_s3;
		pv_s4   <= pv_s3;
	end

	// ---------------- s5: b*b and |a|*c ----------------
	logic                  vld_s5;
	logic        [RW-1:0]  bb_s5, ac_s5;
	logic        [3*AW-1:0] abc_s5;
	logic        [4*W-1:0]  pv_s5;

	always_ff @(posedge clk) begin
		bb_s5  <= {bhh_s4, bll_s4} + (RW'(bhl_s4) << (W + 1));
		ac_s5  <= {ahch_s4, alcl_s4} + ((RW'(ahcl_s4) + RW'(alch_s4)) << W);
		abc_s5 <= abc_s4;
		pv_s5  <= pv_s4;
	end

	// ---------------- s6 / root stages: discriminant and floor sqrt ----------------
	logic [DW-1:0] disc_w;
	logic          dpos_w;
	always_comb begin
		disc_w = abc_s5[3*AW-1] ? (DW'(bb_s5) + DW'(ac_s5)) : (DW'(bb_s5) - DW'(ac_s5));
		dpos_w = ~disc_w[DW-1] & (disc_w != '0);
	end

	logic             rt_vld_sk  [0:QW];
	logic             rt_dpos_sk [0:QW];
	logic [RW-1:0]    rt_rad_sk  [0:QW-1];
	logic [RMW-1:0]   rt_rem_sk  [0:QW-1];
	logic [QW-1:0]    rt_root_sk [0:QW];
	logic [3*AW-1:0]  rt_abc_sk  [0:QW];
	logic [4*W-1:0]   rt_pv_sk   [0:QW];

	always_ff @(posedge clk) begin
		rt_rad_sk[0]  <= dpos_w ? disc_w[RW-1:0] : '0;
		rt_rem_sk[0]  <= '0;
		rt_root_sk[0] <= '0;
		rt_dpos_sk[0] <= dpos_w;
		rt_abc_sk[0]  <= abc_s5;
		rt_pv_sk[0]   <= pv_s5;
	end

	for (genvar k = 0; k < QW; k++) begin : g_root
		logic [RMW-1:0] rem2, trial, rem_n;
		logic           ge;
		always_comb begin
			rem2  = {rt_rem_sk[k][RMW-3:0], rt_rad_sk[k][RW-1:RW-2]};
			trial = {rt_root_sk[k], 2'b01};
			ge    = rem2 >= trial;
			rem_n = ge ? rem2 - trial : rem2;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_sk[k+1] <= 1'b0;
			end else begin
				rt_vld_sk[k+1] <= rt_vld_sk[k];
			end
		end
		always_ff @(posedge clk) begin
			rt_root_sk[k+1] <= {rt_root_sk[k][QW-2:0], ge};
			rt_dpos_sk[k+1] <= rt_dpos_sk[k];
			rt_abc_sk[k+1]  <= rt_abc_sk[k];
			rt_pv_sk[k+1]   <= rt_pv_sk[k];
		end
		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rt_rem_sk[k+1] <= rem_n;
				rt_rad_sk[k+1] <= {rt_rad_sk[k][RW-3:0], 2'b00};
			end
		end
	end

	// ---------------- s7: stable root f ----------------
	logic                  vld_s7, dpos_s7;
	logic signed [FW-1:0]  f_s7;
	logic        [3*AW-1:0] abc_s7;
	logic        [4*W-1:0]  pv_s7;
	logic signed [AW-1:0]  b_root;
	logic signed [FW-1:0]  sq_w;
	assign b_root = $signed(rt_abc_sk[QW][2*AW-1:AW]);
	assign sq_w   = FW'($signed({1'b0, rt_root_sk[QW]}));

	always_ff @(posedge clk) begin
		if (~b_root[AW-1] && (b_root != '0)) begin
			f_s7 <= -(FW'(b_root) + sq_w);
		end else begin
			f_s7 <= sq_w - FW'(b_root);
		end
		dpos_s7 <= rt_dpos_sk[QW];
		abc_s7  <= rt_abc_sk[QW];
		pv_s7   <= rt_pv_sk[QW];
	end

	// ---------------- s8: divider set-up ----------------
	logic signed [AW-1:0] a7, b7, c7;
	logic signed [FW-1:0] num_a;
	logic        [FW-1:0] num_a_abs, f_abs;
	logic        [AW-1:0] a_abs;
	logic                 a_zero, f_zero, c_zero;
	ctl_t                 ctl_w;

	assign a7 = $signed(abc_s7[3*AW-1:2*AW]);
	assign b7 = $signed(abc_s7[2*AW-1:AW]);
	assign c7 = $signed(abc_s7[AW-1:0]);

	always_comb begin
		num_a     = dpos_s7 ? f_s7 : -FW'(b7);
		num_a_abs = num_a[FW-1] ? FW'(-num_a) : FW'(num_a);
		f_abs     = f_s7[FW-1] ? FW'(-f_s7) : FW'(f_s7);
		a_abs     = a7[AW-1] ? AW'(-a7) : AW'(a7);
		a_zero    = (a7 == '0);
		f_zero    = (f_s7 == '0);
		c_zero    = (c7 == '0);
		ctl_w.neg_a = num_a[FW-1] ^ a7[AW-1];
		ctl_w.neg_b = f_s7[FW-1];   // c is never negative
		ctl_w.deg   = dpos_s7 ? f_zero : a_zero;
		if (!dpos_s7) begin
			ctl_w.sel = SEL_A;      // closest approach: -b / a
		end else if (a_zero || (f_s7[FW-1] != a7[AW-1])) begin
			ctl_w.sel = SEL_B;
		end else if (c_zero || f_s7[FW-1]) begin
			ctl_w.sel = SEL_A;
		end else begin
			ctl_w.sel = SEL_MIN;
		end
	end

	logic             dv_vld_sk   [0:NW];
	logic [ACW-1:0]   dv_acc_a_sk [0:NW];
	logic [ACW-1:0]   dv_acc_b_sk [0:NW];
	logic [DVW-1:0]   dv_den_a_sk [0:NW-1];
	logic [DVW-1:0]   dv_den_b_sk [0:NW-1];
	ctl_t             dv_ctl_sk   [0:NW];
	logic [4*W-1:0]   dv_pv_sk    [0:NW];

	always_ff @(posedge clk) begin
		dv_acc_a_sk[0] <= ACW'({num_a_abs[DVW-1:0], {F{1'b0}}});
		dv_acc_b_sk[0] <= ACW'({c7[DVW-1:0], {F{1'b0}}});
		dv_den_a_sk[0] <= a_zero ? DVW'(1) : a_abs[DVW-1:0];
		dv_den_b_sk[0] <= f_zero ? DVW'(1) : f_abs[DVW-1:0];
		dv_ctl_sk[0]   <= ctl_w;
		dv_pv_sk[0]    <= pv_s7;
	end

	// two restoring dividers, one quotient bit per stage
	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [ACW:0]  sh_a, sh_b;
		logic [DVW:0]  hi_a, hi_b, rm_a, rm_b;
		logic          ge_a, ge_b;
		always_comb begin
			sh_a = {dv_acc_a_sk[k], 1'b0};
			sh_b = {dv_acc_b_sk[k], 1'b0};
			hi_a = sh_a[ACW:NW];
			hi_b = sh_b[ACW:NW];
			ge_a = hi_a >= {1'b0, dv_den_a_sk[k]};
			ge_b = hi_b >= {1'b0, dv_den_b_sk[k]};
			rm_a = ge_a ? hi_a - {1'b0, dv_den_a_sk[k]} : hi_a;
			rm_b = ge_b ? hi_b - {1'b0, dv_den_b_sk[k]} : hi_b;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sk[k+1] <= 1'b0;
			end else begin
				dv_vld_sk[k+1] <= dv_vld_sk[k];
			end
		end
		always_ff @(posedge clk) begin
			dv_acc_a_sk[k+1] <= {rm_a[DVW-1:0], sh_a[NW-1:1], ge_a};
			dv_acc_b_sk[k+1] <= {rm_b[DVW-1:0], sh_b[NW-1:1], ge_b};
			dv_ctl_sk[k+1]   <= dv_ctl_sk[k];
			dv_pv_sk[k+1]    <= dv_pv_sk[k];
		end
		if (k < NW - 1) begin : g_den
			always_ff @(posedge clk) begin
				dv_den_a_sk[k+1] <= dv_den_a_sk[k];
				dv_den_b_sk[k+1] <= dv_den_b_sk[k];
			end
		end
	end

	// ---------------- s9: pick the time, clamp negatives ----------------
	logic            vld_s9, deg_s9;
	logic [NW-1:0]   t_s9;
	logic [4*W-1:0]  pv_s9;
	logic [NW-1:0]   qa_w, qb_w, t_w;
	ctl_t            ctl_end;
	assign ctl_end = dv_ctl_sk[NW];

	always_comb begin
		qa_w = ctl_end.neg_a ? '0 : dv_acc_a_sk[NW][NW-1:0];
		qb_w = ctl_end.neg_b ? '0 : dv_acc_b_sk[NW][NW-1:0];
		case (ctl_end.sel)
			SEL_A:   t_w = qa_w;
			SEL_B:   t_w = qb_w;
			SEL_MIN: t_w = (qa_w <= qb_w) ? qa_w : qb_w;
			default: t_w = '0;
		endcase
		if (ctl_end.deg) begin
			t_w = '0;
		end
	end

	always_ff @(posedge clk) begin
		t_s9   <= t_w;
		deg_s9 <= ctl_end.deg;
		pv_s9  <= dv_pv_sk[NW];
	end

	// ---------------- s10: t*v partial products ----------------
	logic                  vld_s10, deg_s10;
	logic signed [PPW-1:0] ppx_s10 [0:TCH-1];
	logic signed [PPW-1:0] ppy_s10 [0:TCH-1];
	logic        [4*W-1:0] pv_s10;
	logic        [TPW-1:0] t_pad;
	logic signed [W-1:0]   vx9, vy9;
	assign t_pad = TPW'(t_s9);
	assign vx9   = $signed(pv_s9[2*W-1:W]);
	assign vy9   = $signed(pv_s9[W-1:0]);

	for (genvar k = 0; k < TCH; k++) begin : g_pp
		always_ff @(posedge clk) begin
			ppx_s10[k] <= $signed({1'b0, t_pad[k*W +: W]}) * vx9;
			ppy_s10[k] <= $signed({1'b0, t_pad[k*W +: W]}) * vy9;
		end
	end

	always_ff @(posedge clk) begin
		deg_s10 <= deg_s9;
		pv_s10  <= pv_s9;
	end

	// ---------------- s11: sum partial products ----------------
	logic                  vld_s11, deg_s11;
	logic signed [PW-1:0]  prod_x_s11, prod_y_s11;
	logic        [4*W-1:0] pv_s11;
	logic signed [PW-1:0]  sum_x, sum_y;

	always_comb begin
		sum_x = '0;
		sum_y = '0;
		for (int k = 0; k < TCH; k++) begin
			sum_x = sum_x + (PW'(ppx_s10[k]) <<< (k*W));
			sum_y = sum_y + (PW'(ppy_s10[k]) <<< (k*W));
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s11 <= sum_x;
		prod_y_s11 <= sum_y;
		deg_s11    <= deg_s10;
		pv_s11     <= pv_s10;
	end

	// ---------------- s12: p + t*v, saturate ----------------
	logic                 vld_s12, deg_s12;
	logic signed [W-1:0]  aim_x_s12, aim_y_s12;
	logic signed [SW-1:0] ext_x, ext_y;
	logic signed [W-1:0]  px11, py11;
	assign px11 = $signed(pv_s11[4*W-1:3*W]);
	assign py11 = $signed(pv_s11[3*W-1:2*W]);

	always_comb begin
		ext_x = SW'(px11) + SW'(prod_x_s11 >>> F);   // floor shift
		ext_y = SW'(py11) + SW'(prod_y_s11 >>> F);
	end

	always_ff @(posedge clk) begin
		if (ext_x > SAT_HI) begin
			aim_x_s12 <= SAT_HI[W-1:0];
		end else if (ext_x < SAT_LO) begin
			aim_x_s12 <= SAT_LO[W-1:0];
		end else begin
			aim_x_s12 <= ext_x[W-1:0];
		end
		if (ext_y > SAT_HI) begin
			aim_y_s12 <= SAT_HI[W-1:0];
		end else if (ext_y < SAT_LO) begin
			aim_y_s12 <= SAT_LO[W-1:0];
		end else begin
			aim_y_s12 <= ext_y[W-1:0];
		end
		deg_s12 <= deg_s11;
	end

	// ---------------- valid bits outside the iterative sections ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			vld_s5       <= 1'b0;
			rt_vld_sk[0] <= 1'b0;
			vld_s7       <= 1'b0;
			dv_vld_sk[0] <= 1'b0;
			vld_s9       <= 1'b0;
			vld_s10      <= 1'b0;
			vld_s11      <= 1'b0;
			vld_s12      <= 1'b0;
		end else begin
			vld_s1       <= take;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_s5       <= vld_s4;
			rt_vld_sk[0] <= vld_s5;
			vld_s7       <= rt_vld_sk[QW];
			dv_vld_sk[0] <= vld_s7;
			vld_s9       <= dv_vld_sk[NW];
			vld_s10      <= vld_s9;
			vld_s11      <= vld_s10;
			vld_s12      <= vld_s11;
		end
	end

	assign done       = vld_s12;
	assign aim_x      = aim_x_s12;
	assign aim_y      = aim_y_s12;
	assign degenerate = deg_s12;

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##LAT done)
		else $error("accepted word did not come out after LAT cycles");

	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, LAT))
		else $error("result strobe without a matching accepted word");

	a_deg_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |->
			(aim_x == $past(pos_x, LAT)) && (aim_y == $past(pos_y, LAT)))
		else $error("degenerate result does not return the position");

	a_root_nz: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && dpos_s7 |-> (f_s7 != '0))
		else $error("stable root zero with positive discriminant");

endmodule
